@@ sv/assert_macros.svh @@
// Assertion macros used by the tally top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define WVQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define WVQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/wvq_pkg.sv @@
// Types, constants and helper functions of the weighted vote quorum tally.
package wvq_pkg;

  localparam int MAX_VOTERS = 1024;
  localparam int ADDR_W     = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
  localparam int CLR_W      = ADDR_W + 1;
  localparam int LIMIT_W    = 17;
  localparam int IDX_W      = 10;
  localparam int WEIGHT_W   = 64;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_BAD_SIG   = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    TM_UNRESTRICTED  = 3'd0,
    TM_RESTRICTED    = 3'd1,
    TM_WEAK_QUORUM   = 3'd2,
    TM_WEAK_FINAL    = 3'd3,
    TM_STRONG        = 3'd4
  } tally_code_t;

  typedef enum logic [4:0] {
    M_UNRES  = 5'b00001,
    M_RESTR  = 5'b00010,
    M_WACH   = 5'b00100,
    M_WFIN   = 5'b01000,
    M_STRONG = 5'b10000
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUORUM      = 2'd0,
    CFG_WEAK_LIMIT  = 2'd1,
    CFG_VOTER_COUNT = 2'd2
  } cfg_reg_t;

  // One bitmap entry: both vote kinds of one voter.
  typedef struct packed {
    logic strong_seen;
    logic weak_seen;
  } seen_t;

  // Second stage word handed to the mode stage.
  typedef struct packed {
    logic                valid;
    status_t             status;
    logic                strong_vote;
    logic                accepted;
    logic [WEIGHT_W-1:0] strong_total;
    logic [WEIGHT_W-1:0] weak_total;
  } tally_t;

  function automatic logic [WEIGHT_W-1:0] sat_add(input logic [WEIGHT_W-1:0] a,
                                                  input logic [WEIGHT_W-1:0] b);
    logic [WEIGHT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WEIGHT_W] ? {WEIGHT_W{1'b1}} : s[WEIGHT_W-1:0];
  endfunction

  function automatic tally_code_t mode_code(input mode_t m);
    tally_code_t c;
    case (m)
      M_UNRES:  c = TM_UNRESTRICTED;
      M_RESTR:  c = TM_RESTRICTED;
      M_WACH:   c = TM_WEAK_QUORUM;
      M_WFIN:   c = TM_WEAK_FINAL;
      M_STRONG: c = TM_STRONG;
      default:  c = TM_UNRESTRICTED;
    endcase
    return c;
  endfunction

endpackage

@@ sv/wvq_vote_if.sv @@
// Vote input channel.
interface wvq_vote_if;
  logic                          valid;
  logic                          ready;
  logic                          strong_vote;
  logic [wvq_pkg::IDX_W-1:0]     voter_index;
  logic [wvq_pkg::WEIGHT_W-1:0]  vote_weight;
  logic                          sig_ok;

  modport source (output valid, strong_vote, voter_index, vote_weight, sig_ok,
                  input ready);
  modport sink (input valid, strong_vote, voter_index, vote_weight, sig_ok,
                output ready);
endinterface

@@ sv/wvq_result_if.sv @@
// Result output channel.
interface wvq_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] tally_mode;
  logic       quorum_reached;

  modport source (output valid, status, tally_mode, quorum_reached, input ready);
  modport sink (input valid, status, tally_mode, quorum_reached, output ready);
endinterface

@@ sv/wvq_cfg_if.sv @@
// Configuration write channel.
interface wvq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wvq_pkg::CFG_IDX_W-1:0]  index;
  logic [wvq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/wvq_seen_mem.sv @@
// Voter bitmap memory with post-reset clear sweep and write-to-read forwarding.
module wvq_seen_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [wvq_pkg::ADDR_W-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic [wvq_pkg::ADDR_W-1:0] wr_addr,
  input  wvq_pkg::seen_t             wr_data,
  output wvq_pkg::seen_t             rd_data,
  output logic                       busy
);

  wvq_pkg::seen_t                    mem [wvq_pkg::MAX_VOTERS];
  wvq_pkg::seen_t                    rd_q_r;
  wvq_pkg::seen_t                    fwd_data_r;
  logic                              fwd_hit_r;
  logic [wvq_pkg::CLR_W-1:0]         clr_cnt_r;
  logic                              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == wvq_pkg::CLR_W'(wvq_pkg::MAX_VOTERS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r[wvq_pkg::ADDR_W-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // a write in the same cycle as the read lands after the read; pass it on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;
  assign busy    = busy_r;

endmodule

@@ sv/wvq_check.sv @@
// Vote check stage: range, duplicate and signature tests, bitmap update, saturating sums.
module wvq_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic                         s1_en,
  input  logic                         s2_en,
  input  logic                         in_strong_vote,
  input  logic [wvq_pkg::IDX_W-1:0]    in_voter_index,
  input  logic [wvq_pkg::WEIGHT_W-1:0] in_vote_weight,
  input  logic                         in_sig_ok,
  input  logic [wvq_pkg::CNT_W-1:0]    voter_count,
  input  wvq_pkg::seen_t               seen,
  output logic                         s1_valid,
  output logic                         wr_en,
  output logic [wvq_pkg::ADDR_W-1:0]   wr_addr,
  output wvq_pkg::seen_t               wr_data,
  output wvq_pkg::tally_t              s2
);

  logic                         s1_v_r;
  logic                         s1_strong_r;
  logic [wvq_pkg::IDX_W-1:0]    s1_idx_r;
  logic [wvq_pkg::WEIGHT_W-1:0] s1_weight_r;
  logic                         s1_sig_r;

  logic [wvq_pkg::WEIGHT_W-1:0] strong_total_r;
  logic [wvq_pkg::WEIGHT_W-1:0] weak_total_r;
  logic [wvq_pkg::WEIGHT_W-1:0] strong_nxt;
  logic [wvq_pkg::WEIGHT_W-1:0] weak_nxt;

  wvq_pkg::tally_t              s2_r;

  logic [wvq_pkg::LIMIT_W-1:0]  vc_ext;
  logic [wvq_pkg::LIMIT_W-1:0]  max_ext;
  logic [wvq_pkg::LIMIT_W-1:0]  limit;
  logic                         in_range;
  logic                         dup;
  logic                         ok;
  wvq_pkg::status_t             status;

  always_comb begin
    vc_ext   = wvq_pkg::LIMIT_W'(voter_count);
    max_ext  = wvq_pkg::LIMIT_W'(wvq_pkg::MAX_VOTERS);
    limit    = (vc_ext > max_ext) ? max_ext : vc_ext;
    in_range = wvq_pkg::LIMIT_W'(s1_idx_r) < limit;
    dup      = s1_strong_r ? seen.strong_seen : seen.weak_seen;
    ok       = in_range && !dup && s1_sig_r;
    if (!in_range) begin
      status = wvq_pkg::ST_RANGE;
    end else if (dup) begin
      status = wvq_pkg::ST_DUPLICATE;
    end else if (!s1_sig_r) begin
      status = wvq_pkg::ST_BAD_SIG;
    end else begin
      status = wvq_pkg::ST_SUCCESS;
    end
    strong_nxt = (ok && s1_strong_r) ? wvq_pkg::sat_add(strong_total_r, s1_weight_r)
                                     : strong_total_r;
    weak_nxt   = (ok && !s1_strong_r) ? wvq_pkg::sat_add(weak_total_r, s1_weight_r)
                                      : weak_total_r;
    wr_data             = seen;
    wr_data.strong_seen = seen.strong_seen | s1_strong_r;
    wr_data.weak_seen   = seen.weak_seen | !s1_strong_r;
  end

  assign wr_en    = s1_v_r && s1_en && ok;
  assign wr_addr  = wvq_pkg::ADDR_W'(s1_idx_r);
  assign s1_valid = s1_v_r;
  assign s2       = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      s2_r.valid     <= 1'b0;
      strong_total_r <= '0;
      weak_total_r   <= '0;
    end else begin
      if (s1_en) begin
        s1_v_r <= load;
      end
      if (s2_en) begin
        s2_r.valid        <= s1_v_r;
        s2_r.status       <= status;
        s2_r.strong_vote  <= s1_strong_r;
        s2_r.accepted     <= ok;
        s2_r.strong_total <= strong_nxt;
        s2_r.weak_total   <= weak_nxt;
      end
      if (s1_v_r && s1_en) begin
        strong_total_r <= strong_nxt;
        weak_total_r   <= weak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_strong_r <= in_strong_vote;
      s1_idx_r    <= in_voter_index;
      s1_weight_r <= in_vote_weight;
      s1_sig_r    <= in_sig_ok;
    end
  end

endmodule

@@ sv/wvq_mode.sv @@
// Quorum mode machine and result register.
module wvq_mode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         out_en,
  input  wvq_pkg::tally_t              s2,
  input  logic [wvq_pkg::WEIGHT_W-1:0] quorum_weight,
  input  logic [wvq_pkg::WEIGHT_W-1:0] weak_limit,
  output logic                         out_valid,
  output wvq_pkg::status_t             out_status,
  output wvq_pkg::tally_code_t         out_tally_mode,
  output logic                         out_quorum_reached,
  output wvq_pkg::mode_t               mode
);

  wvq_pkg::mode_t               mode_r;
  wvq_pkg::mode_t               mode_nxt;
  wvq_pkg::mode_t               weak_step;
  logic [wvq_pkg::WEIGHT_W-1:0] total;
  logic                         strong_ge;
  logic                         total_ge;
  logic                         weak_gt;
  logic                         weak_ge;

  logic                         out_valid_r;
  wvq_pkg::status_t             status_r;
  wvq_pkg::tally_code_t         tally_r;
  logic                         quorum_r;

  always_comb begin
    total     = wvq_pkg::sat_add(s2.strong_total, s2.weak_total);
    strong_ge = s2.strong_total >= quorum_weight;
    total_ge  = total >= quorum_weight;
    weak_gt   = s2.weak_total > weak_limit;
    weak_ge   = s2.weak_total >= weak_limit;

    weak_step = total_ge ? wvq_pkg::M_WACH : mode_r;
    if (weak_gt) begin
      if (weak_step == wvq_pkg::M_WACH) begin
        weak_step = wvq_pkg::M_WFIN;
      end else if (weak_step == wvq_pkg::M_UNRES) begin
        weak_step = wvq_pkg::M_RESTR;
      end
    end

    mode_nxt = mode_r;
    if (s2.valid && s2.accepted) begin
      if (s2.strong_vote) begin
        case (mode_r)
          wvq_pkg::M_UNRES, wvq_pkg::M_RESTR: begin
            if (strong_ge) begin
              mode_nxt = wvq_pkg::M_STRONG;
            end else if (total_ge) begin
              mode_nxt = (mode_r == wvq_pkg::M_RESTR) ? wvq_pkg::M_WFIN : wvq_pkg::M_WACH;
            end
          end
          wvq_pkg::M_WACH: begin
            if (strong_ge) begin
              mode_nxt = wvq_pkg::M_STRONG;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end else begin
        case (mode_r)
          wvq_pkg::M_UNRES, wvq_pkg::M_RESTR: mode_nxt = weak_step;
          wvq_pkg::M_WACH: begin
            if (weak_ge) begin
              mode_nxt = wvq_pkg::M_WFIN;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= wvq_pkg::M_UNRES;
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s2.valid;
      if (s2.valid) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      status_r <= s2.status;
      tally_r  <= wvq_pkg::mode_code(mode_nxt);
      quorum_r <= (mode_nxt == wvq_pkg::M_WACH) || (mode_nxt == wvq_pkg::M_WFIN) ||
                  (mode_nxt == wvq_pkg::M_STRONG);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_tally_mode     = tally_r;
  assign out_quorum_reached = quorum_r;
  assign mode               = mode_r;

endmodule

@@ sv/weighted_vote_quorum_tally.sv @@
// Weighted vote quorum tally: every accepted vote word yields one result word.
// Throughput one vote word per cycle unless out_res back-pressure or the bitmap clear stalls;
// a bitmap read-modify-write per vote, forwarded. Stages: bitmap read, check/sum update,
// mode update into the result register. rst_n is synchronous; after it the voter bitmap
// is swept clear across all MAX_VOTERS entries, during which in_vote.ready is low; config writes are taken throughout.
`include "assert_macros.svh"

module weighted_vote_quorum_tally (
  input  logic                clk,
  input  logic                rst_n,
  wvq_vote_if.sink            in_vote,
  wvq_result_if.source        out_res,
  wvq_cfg_if.sink             cfg_wr
);

  logic [wvq_pkg::WEIGHT_W-1:0] quorum_r;
  logic [wvq_pkg::WEIGHT_W-1:0] weak_limit_r;
  logic [wvq_pkg::CNT_W-1:0]    voter_count_r;

  logic                         busy;
  logic                         accept;
  logic                         s1_valid;
  logic                         s1_en;
  logic                         s2_en;
  logic                         out_en;
  logic                         wr_en;
  logic [wvq_pkg::ADDR_W-1:0]   wr_addr;
  wvq_pkg::seen_t               wr_data;
  wvq_pkg::seen_t               seen;
  wvq_pkg::tally_t              s2;
  wvq_pkg::status_t             res_status;
  wvq_pkg::tally_code_t         res_mode;
  wvq_pkg::mode_t               mode;
  logic                         res_valid;
  logic                         res_quorum;
  logic                         res_mode_quorum;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quorum_r      <= '0;
      weak_limit_r  <= '0;
      voter_count_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        wvq_pkg::CFG_QUORUM:      quorum_r      <= cfg_wr.data;
        wvq_pkg::CFG_WEAK_LIMIT:  weak_limit_r  <= cfg_wr.data;
        wvq_pkg::CFG_VOTER_COUNT: voter_count_r <= cfg_wr.data[wvq_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_en        = !res_valid || out_res.ready;
  assign s2_en         = !s2.valid || out_en;
  assign s1_en         = !s1_valid || s2_en;
  assign in_vote.ready = s1_en && !busy;
  assign accept        = in_vote.valid && in_vote.ready;

  wvq_seen_mem u_seen (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (wvq_pkg::ADDR_W'(in_vote.voter_index)),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (seen),
    .busy    (busy)
  );

  wvq_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .s1_en          (s1_en),
    .s2_en          (s2_en),
    .in_strong_vote (in_vote.strong_vote),
    .in_voter_index (in_vote.voter_index),
    .in_vote_weight (in_vote.vote_weight),
    .in_sig_ok      (in_vote.sig_ok),
    .voter_count    (voter_count_r),
    .seen           (seen),
    .s1_valid       (s1_valid),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .s2             (s2)
  );

  wvq_mode u_mode (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_en             (out_en),
    .s2                 (s2),
    .quorum_weight      (quorum_r),
    .weak_limit         (weak_limit_r),
    .out_valid          (res_valid),
    .out_status         (res_status),
    .out_tally_mode     (res_mode),
    .out_quorum_reached (res_quorum),
    .mode               (mode)
  );

  assign out_res.valid          = res_valid;
  assign out_res.status         = res_status;
  assign out_res.tally_mode     = res_mode;
  assign out_res.quorum_reached = res_quorum;

  assign res_mode_quorum = (res_mode == wvq_pkg::TM_WEAK_QUORUM) ||
                           (res_mode == wvq_pkg::TM_WEAK_FINAL) ||
                           (res_mode == wvq_pkg::TM_STRONG);

  `WVQ_ASSERT_ALWAYS(a_no_vote_during_clear, busy |-> !in_vote.ready, "vote taken during clear")
  `WVQ_ASSERT(a_no_write_during_clear, wr_en |-> !busy, "bitmap write during clear")
  `WVQ_ASSERT(a_quorum_flag, out_res.valid |-> (res_quorum == res_mode_quorum), "quorum flag")
  `WVQ_ASSERT(a_strong_sticky, ($past(rst_n) && ($past(mode) == wvq_pkg::M_STRONG)) |-> (mode == wvq_pkg::M_STRONG), "mode left strong")

endmodule

@@ tb/tb_top.sv @@
// Testbench for weighted_vote_quorum_tally: directed and random votes against a predictor.
module tb_top;
  import wvq_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_STALL = 80;
  localparam int PHASE_WORDS = 40;
  localparam int RANDOM_PHASES = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [WEIGHT_W-1:0] W_MAX = '1;

  typedef struct packed {
    logic                strong_vote;
    logic [IDX_W-1:0]    voter_index;
    logic [WEIGHT_W-1:0] vote_weight;
    logic                sig_ok;
  } ballot_t;

  typedef struct packed {
    status_t     status;
    tally_code_t mode;
    logic        reached;
  } tally_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wvq_vote_if   vote_bus ();
  wvq_result_if res_bus ();
  wvq_cfg_if    cfg_bus ();

  weighted_vote_quorum_tally uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vote(vote_bus),
    .out_res(res_bus),
    .cfg_wr (cfg_bus)
  );

  // tally predictor state
  bit                  strong_voted [MAX_VOTERS];
  bit                  weak_voted [MAX_VOTERS];
  logic [WEIGHT_W-1:0] strong_sum = '0;
  logic [WEIGHT_W-1:0] weak_sum = '0;
  tally_code_t         cur_mode = TM_UNRESTRICTED;
  logic [WEIGHT_W-1:0] quorum_cfg = '0;
  logic [WEIGHT_W-1:0] weak_limit_cfg = '0;
  logic [CNT_W-1:0]    voter_count_cfg = '0;

  tally_result_t tally_q [$];
  int            err_count = 0;
  int            tx_idle_pct = 18;
  int            rx_idle_pct = 45;
  int            weight_step = 100;
  int unsigned   stall_seq = 0;
  int unsigned   cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [WEIGHT_W-1:0] sat_sum(input logic [WEIGHT_W-1:0] a,
                                                  input logic [WEIGHT_W-1:0] b);
    logic [WEIGHT_W-1:0] s;
    s = a + b;
    return (s < a) ? W_MAX : s;
  endfunction

  function automatic int voter_limit();
    return (voter_count_cfg > MAX_VOTERS) ? MAX_VOTERS : int'(voter_count_cfg);
  endfunction

  function automatic tally_result_t tally_vote(input ballot_t b);
    tally_result_t       r;
    logic [WEIGHT_W-1:0] total;
    r.status = ST_SUCCESS;
    if (int'(b.voter_index) >= voter_limit()) begin
      r.status = ST_RANGE;
    end else if (b.strong_vote ? strong_voted[b.voter_index] : weak_voted[b.voter_index]) begin
      r.status = ST_DUPLICATE;
    end else if (!b.sig_ok) begin
      r.status = ST_BAD_SIG;
    end else if (b.strong_vote) begin
      strong_voted[b.voter_index] = 1'b1;
      strong_sum = sat_sum(strong_sum, b.vote_weight);
      total = sat_sum(weak_sum, strong_sum);
      if (cur_mode == TM_UNRESTRICTED || cur_mode == TM_RESTRICTED) begin
        if (strong_sum >= quorum_cfg)
          cur_mode = TM_STRONG;
        else if (total >= quorum_cfg)
          cur_mode = (cur_mode == TM_RESTRICTED) ? TM_WEAK_FINAL : TM_WEAK_QUORUM;
      end else if (cur_mode == TM_WEAK_QUORUM && strong_sum >= quorum_cfg) begin
        cur_mode = TM_STRONG;
      end
    end else begin
      weak_voted[b.voter_index] = 1'b1;
      weak_sum = sat_sum(weak_sum, b.vote_weight);
      total = sat_sum(weak_sum, strong_sum);
      if (cur_mode == TM_UNRESTRICTED || cur_mode == TM_RESTRICTED) begin
        if (total >= quorum_cfg)
          cur_mode = TM_WEAK_QUORUM;
        // strict compare here, unlike the weak-quorum move below
        if (weak_sum > weak_limit_cfg) begin
          if (cur_mode == TM_WEAK_QUORUM)
            cur_mode = TM_WEAK_FINAL;
          else if (cur_mode == TM_UNRESTRICTED)
            cur_mode = TM_RESTRICTED;
        end
      end else if (cur_mode == TM_WEAK_QUORUM && weak_sum >= weak_limit_cfg) begin
        cur_mode = TM_WEAK_FINAL;
      end
    end
    r.mode = cur_mode;
    r.reached = (cur_mode == TM_WEAK_QUORUM || cur_mode == TM_WEAK_FINAL ||
                 cur_mode == TM_STRONG);
    return r;
  endfunction

  function automatic ballot_t make_ballot(input logic is_strong, input int idx,
                                          input logic [WEIGHT_W-1:0] w, input logic ok);
    ballot_t b;
    b.strong_vote = is_strong;
    b.voter_index = idx[IDX_W-1:0];
    b.vote_weight = w;
    b.sig_ok = ok;
    return b;
  endfunction

  function automatic ballot_t random_ballot();
    ballot_t b;
    int      lim;
    int      pick;
    lim = voter_limit();
    b.strong_vote = 1'($urandom_range(1, 0));
    if (lim > 0 && $urandom_range(99) < 85)
      b.voter_index = IDX_W'($urandom_range(lim - 1, 0));
    else
      b.voter_index = IDX_W'($urandom_range(MAX_VOTERS - 1, 0));
    b.sig_ok = ($urandom_range(99) < 90);
    pick = int'($urandom_range(99));
    if (pick == 0)
      b.vote_weight = W_MAX;
    else if (pick == 1)
      b.vote_weight = {$urandom, $urandom};
    else if (pick < 5)
      b.vote_weight = '0;
    else
      b.vote_weight = WEIGHT_W'($urandom_range(weight_step, 0));
    return b;
  endfunction

  function automatic int free_voter(input logic is_strong);
    for (int i = 0; i < MAX_VOTERS; i++)
      if (!(is_strong ? strong_voted[i] : weak_voted[i]))
        return i;
    return -1;
  endfunction

  // valid stays high between back-to-back words
  task automatic send_vote(input ballot_t b);
    if ($urandom_range(99) < tx_idle_pct) begin
      vote_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    vote_bus.valid       <= 1'b1;
    vote_bus.strong_vote <= b.strong_vote;
    vote_bus.voter_index <= b.voter_index;
    vote_bus.vote_weight <= b.vote_weight;
    vote_bus.sig_ok      <= b.sig_ok;
    do @(posedge clk); while (!vote_bus.ready);
    tally_q.push_back(tally_vote(b));
  endtask

  task automatic drain_votes();
    vote_bus.valid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // call only after drain_votes; the spare index must be ignored
  task automatic apply_config(input logic [WEIGHT_W-1:0] q, input logic [WEIGHT_W-1:0] wl,
                              input logic [CNT_W-1:0] vc);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_QUORUM, CFG_WEAK_LIMIT, CFG_VOTER_COUNT, CFG_SPARE};
    val = '{q, wl, CFG_DATA_W'(vc), {$urandom, $urandom}};
    for (int i = 0; i < 4; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= val[i];
      do @(posedge clk); while (!cfg_bus.ready);
      case (idx[i])
        CFG_QUORUM:      quorum_cfg = val[i];
        CFG_WEAK_LIMIT:  weak_limit_cfg = val[i];
        CFG_VOTER_COUNT: voter_count_cfg = val[i][CNT_W-1:0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // voter_count is zero after reset, so every index is out of range
  task automatic test_unconfigured_range();
    send_vote(make_ballot(1'b1, 0, W_MAX, 1'b1));
    send_vote(make_ballot(1'b0, MAX_VOTERS - 1, '0, 1'b1));
    send_vote(make_ballot(1'b1, 512, 64'h5555_AAAA_5555_AAAA, 1'b0));
  endtask

  task automatic test_reject_order();
    drain_votes();
    apply_config(64'd1000, 64'd100, 11'd1024);
    send_vote(make_ballot(1'b1, 0, 64'd10, 1'b1));
    send_vote(make_ballot(1'b1, 0, 64'd10, 1'b1));
    send_vote(make_ballot(1'b1, 0, 64'd10, 1'b0));            // duplicate wins over bad sig
    send_vote(make_ballot(1'b0, 0, 64'd7, 1'b0));
    send_vote(make_ballot(1'b0, 0, 64'd100, 1'b1));           // weak sum equals limit
    send_vote(make_ballot(1'b0, MAX_VOTERS - 1, 64'd1, 1'b1)); // now above: restricted
    send_vote(make_ballot(1'b1, 1, 64'd0, 1'b1));
    send_vote(make_ballot(1'b0, MAX_VOTERS - 1, 64'd1, 1'b1));
  endtask

  task automatic test_index_limit();
    drain_votes();
    apply_config(64'd1000, 64'd100, 11'd1000);
    send_vote(make_ballot(1'b0, 1000, 64'd5, 1'b0));
    send_vote(make_ballot(1'b0, 999, 64'd5, 1'b1));
  endtask

  task automatic test_mode_walk();
    drain_votes();
    apply_config(64'd150, W_MAX, 11'd1024);
    send_vote(make_ballot(1'b0, 2, 64'd40, 1'b1));   // restricted to weak quorum
    send_vote(make_ballot(1'b1, 2, 64'd100, 1'b1));  // strong sum still short
    drain_votes();
    apply_config(64'd150, 64'd200, 11'd1024);
    send_vote(make_ballot(1'b0, 3, 64'd53, 1'b1));   // one below weak limit
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    stall_seq <= stall_seq + 1;
    repeat (30) send_vote(random_ballot());
    tx_idle_pct = 18;
  endtask

  task automatic test_random_phases();
    logic [WEIGHT_W-1:0] q;
    logic [WEIGHT_W-1:0] wl;
    logic [CNT_W-1:0]    vc;
    int                  sel;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_votes();
      q = sat_sum(sat_sum(strong_sum, weak_sum), WEIGHT_W'($urandom_range(20000, 200)));
      wl = sat_sum(weak_sum, WEIGHT_W'($urandom_range(10000, 50)));
      sel = int'($urandom_range(5));
      if (sel == 0) begin
        q = '0;
      end else if (sel == 1) begin
        q = W_MAX;
        wl = W_MAX;
      end else if (sel == 2) begin
        wl = '0;
      end
      sel = int'($urandom_range(19));
      if (sel == 0)
        vc = '0;
      else if (sel == 1)
        vc = 11'd1;
      else if (sel < 4)
        vc = 11'd1024;
      else if (sel == 4)
        vc = '1;
      else if (sel == 5)
        vc = 11'd1025;
      else
        vc = CNT_W'($urandom_range(1024, 2));
      apply_config(q, wl, vc);
      weight_step = int'($urandom_range(3000, 20));
      tx_idle_pct = (p < RANDOM_PHASES / 3) ? 18 : (p < 2 * RANDOM_PHASES / 3) ? 45 : 0;
      rx_idle_pct <= (p < RANDOM_PHASES / 3) ? 45 : (p < 2 * RANDOM_PHASES / 3) ? 18 : 0;
      repeat (PHASE_WORDS) send_vote(random_ballot());
    end
  endtask

  // both sums are already nonzero, so every vote here pushes its sum past 2^64-1
  task automatic test_saturation();
    int   idx;
    logic kind;
    drain_votes();
    apply_config(W_MAX, W_MAX, '1);
    for (int k = 0; k < 4; k++) begin
      kind = (k < 2);
      idx = free_voter(kind);
      if (idx >= 0)
        send_vote(make_ballot(kind, idx, W_MAX, 1'b1));
    end
  endtask

  initial begin
    vote_bus.valid       <= 1'b0;
    vote_bus.strong_vote <= 1'b0;
    vote_bus.voter_index <= '0;
    vote_bus.vote_weight <= '0;
    vote_bus.sig_ok      <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_unconfigured_range();
    test_reject_order();
    test_index_limit();
    test_mode_walk();
    test_backpressure();
    test_random_phases();
    test_saturation();

    drain_votes();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // result sink: random stalls plus one long hold-off on request
  initial begin : result_sink
    int          stall_left;
    int unsigned stall_seen;
    stall_left = 0;
    stall_seen = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_seq != stall_seen) begin
        stall_seen = stall_seq;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    tally_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (tally_q.size() == 0) begin
        $error("result word with no vote pending");
        err_count++;
      end else begin
        want = tally_q.pop_front();
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_bus.status);
          err_count++;
        end
        if (res_bus.tally_mode !== want.mode) begin
          $error("tally_mode: expected %0d, got %0d", want.mode, res_bus.tally_mode);
          err_count++;
        end
        if (res_bus.quorum_reached !== want.reached) begin
          $error("quorum_reached: expected %0d, got %0d", want.reached,
                 res_bus.quorum_reached);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $error("timeout with %0d results outstanding", tally_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
